// File: rtl/core/rfd_pkg.sv
// Shared types and constants of the range frame deframer.
package rfd_pkg;

  localparam int RX_W       = 8;
  localparam int VALUE_W    = 16;
  localparam int INDEX_W    = 9;
  localparam int HDR_W      = 64;
  localparam int HLEN_W     = 4;
  localparam int PWORDS_W   = 10;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [HDR_W-1:0]    HDR_RESET    = '0;
  localparam logic [HLEN_W-1:0]   HLEN_RESET   = 4'd7;
  localparam logic [PWORDS_W-1:0] PWORDS_RESET = 10'd361;

  // Word queue between the byte front end and the output stage
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTES  = 2'd0,
    CFG_HEADER_LEN    = 2'd1,
    CFG_PAYLOAD_WORDS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RX_W-1:0]    low_byte;
    logic [RX_W-1:0]    high_byte;
    logic [INDEX_W-1:0] index;
    logic               last;
  } word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/rfd_front.sv
// Byte front end: config registers, header hunt and word pairing.
module rfd_front #(
  parameter int MAX_HEADER = 8,
  parameter int MAX_WORDS  = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            byte_accept,
  input  logic [rfd_pkg::RX_W-1:0]        rx_byte,
  output logic                            q_push,
  output rfd_pkg::word_t                  q_item
);

  localparam int HIST_W = 8 * MAX_HEADER;
  localparam int HC_W   = $clog2(MAX_HEADER + 1);
  localparam int IDX_W  = $clog2(MAX_WORDS);
  localparam int CMP_W  = (IDX_W + 1 > rfd_pkg::PWORDS_W) ? IDX_W + 1 : rfd_pkg::PWORDS_W;

  logic [HIST_W-1:0]                hdr_r;
  logic [rfd_pkg::HLEN_W-1:0]       hlen_r;
  logic [rfd_pkg::PWORDS_W-1:0]     pwords_r;

  logic [HIST_W-1:0]                hist_r, hist_nxt;
  logic [HC_W-1:0]                  hcnt_r, hcnt_nxt;
  logic                             in_payload_r, in_payload_nxt;
  logic                             have_low_r, have_low_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [rfd_pkg::RX_W-1:0]         low_r, low_nxt;

  logic [HIST_W-1:0]                hist_shift;
  logic [HC_W-1:0]                  hcnt_inc;
  logic [rfd_pkg::HLEN_W-1:0]       keff;
  logic                             hit;
  logic                             ok;
  logic [CMP_W-1:0]                 weff;
  logic [CMP_W-1:0]                 idx_plus;
  logic                             last;
  logic [IDX_W+rfd_pkg::INDEX_W-1:0] idx_ext;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= rfd_pkg::HDR_RESET[HIST_W-1:0];
      hlen_r   <= rfd_pkg::HLEN_RESET;
      pwords_r <= rfd_pkg::PWORDS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rfd_pkg::CFG_HEADER_BYTES:  hdr_r    <= cfg_data[HIST_W-1:0];
        rfd_pkg::CFG_HEADER_LEN:    hlen_r   <= cfg_data[rfd_pkg::HLEN_W-1:0];
        rfd_pkg::CFG_PAYLOAD_WORDS: pwords_r <= cfg_data[rfd_pkg::PWORDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp header length and payload size
  always_comb begin
    if (hlen_r == '0) keff = rfd_pkg::HLEN_W'(1);
    else if (hlen_r > rfd_pkg::HLEN_W'(MAX_HEADER)) keff = rfd_pkg::HLEN_W'(MAX_HEADER);
    else keff = hlen_r;

    if (pwords_r == '0) weff = CMP_W'(1);
    else if (CMP_W'(pwords_r) > CMP_W'(MAX_WORDS)) weff = CMP_W'(MAX_WORDS);
    else weff = CMP_W'(pwords_r);
  end

  assign hist_shift = (hist_r << 8) | HIST_W'(rx_byte);
  assign hcnt_inc   = (hcnt_r < HC_W'(MAX_HEADER)) ? hcnt_r + HC_W'(1) : hcnt_r;

  // Newest byte sits at position 0; header byte j must sit at position k-1-j
  always_comb begin
    hit = 1'b0;
    ok  = 1'b0;
    for (int k = 1; k <= MAX_HEADER; k++) begin
      ok = 1'b1;
      for (int j = 0; j < k; j++) begin
        if (hist_shift[8*(k-1-j) +: 8] != hdr_r[8*j +: 8]) ok = 1'b0;
      end
      if (keff == rfd_pkg::HLEN_W'(k)) hit = ok;
    end
  end

  assign idx_plus = CMP_W'(idx_r) + CMP_W'(1);
  assign last     = (idx_plus >= weff);
  assign idx_ext  = {{rfd_pkg::INDEX_W{1'b0}}, idx_r};

  always_comb begin
    hist_nxt       = hist_r;
    hcnt_nxt       = hcnt_r;
    in_payload_nxt = in_payload_r;
    have_low_nxt   = have_low_r;
    idx_nxt        = idx_r;
    low_nxt        = low_r;
    q_push         = 1'b0;
    if (byte_accept) begin
      if (!in_payload_r) begin
        hist_nxt = hist_shift;
        hcnt_nxt = hcnt_inc;
        if ((rfd_pkg::HLEN_W'(hcnt_inc) >= keff) && hit) begin
          in_payload_nxt = 1'b1;
          hist_nxt       = '0;
          hcnt_nxt       = '0;
          have_low_nxt   = 1'b0;
          idx_nxt        = '0;
        end
      end else if (!have_low_r) begin
        low_nxt      = rx_byte;
        have_low_nxt = 1'b1;
      end else begin
        q_push       = 1'b1;
        have_low_nxt = 1'b0;
        if (last) begin
          in_payload_nxt = 1'b0;
          idx_nxt        = '0;
          hist_nxt       = '0;
          hcnt_nxt       = '0;
        end else begin
          idx_nxt = idx_plus[IDX_W-1:0];
        end
      end
    end
  end

  assign q_item.low_byte  = low_r;
  assign q_item.high_byte = rx_byte;
  assign q_item.index     = idx_ext[rfd_pkg::INDEX_W-1:0];
  assign q_item.last      = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      hcnt_r       <= '0;
      in_payload_r <= 1'b0;
      have_low_r   <= 1'b0;
      idx_r        <= '0;
    end else begin
      hist_r       <= hist_nxt;
      hcnt_r       <= hcnt_nxt;
      in_payload_r <= in_payload_nxt;
      have_low_r   <= have_low_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r <= low_nxt;
  end

endmodule

// File: rtl/core/rfd_queue.sv
// Two-entry word queue between front end and output stage.
module rfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rfd_pkg::word_t      push_item,
  input  logic                pop,
  output rfd_pkg::word_t      head_item,
  output rfd_pkg::q_status_t  status
);

  rfd_pkg::word_t                 mem_r [rfd_pkg::Q_DEPTH];
  logic [rfd_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [rfd_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == rfd_pkg::Q_CNT_W'(rfd_pkg::Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head_item    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + rfd_pkg::Q_CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - rfd_pkg::Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + rfd_pkg::Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + rfd_pkg::Q_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: rtl/core/rfd_back.sv
// Output stage: builds the range word and holds it until taken.
module rfd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rfd_pkg::word_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfd_pkg::VALUE_W-1:0]   out_range_value,
  output logic [rfd_pkg::INDEX_W-1:0]   out_range_index,
  output logic                          out_last_word
);

  logic                          valid_r;
  logic [rfd_pkg::VALUE_W-1:0]   value_r;
  logic [rfd_pkg::INDEX_W-1:0]   index_r;
  logic                          last_r;

  // Load whenever the register is empty or being taken
  assign q_pop = q_valid && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      value_r <= {q_item.high_byte, q_item.low_byte};
      index_r <= q_item.index;
      last_r  <= q_item.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_range_value = value_r;
  assign out_range_index = index_r;
  assign out_last_word   = last_r;

endmodule

// File: rtl/core/range_frame_deframer.sv
// Top level of the range frame deframer.
//
//  channel | ports                                    | direction | transaction
//  --------+------------------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, in_rx_byte           | input     | one received byte
//  out     | out_valid, out_stall, out_range_value,   | output    | one range word
//          | out_range_index, out_last_word           |           |
//  cfg     | cfg_wr_en, cfg_index, cfg_data           | input     | one register write
//
//  One byte is taken every cycle while in_stall is low; a word reaches the output
//  register by way of the word queue (the edge that takes its high byte writes the
//  queue, and the output register loads from it when empty or being taken). The
//  combinational hunt compare and pairing logic sets that rate.
//  in_stall rises only when the two-entry queue has filled behind a stalled
//  output register. Reset is synchronous: config registers go to their defaults and
//  the hunt restarts with an empty history.
module range_frame_deframer #(
  parameter int MAX_HEADER = 8,
  parameter int MAX_WORDS  = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rfd_pkg::RX_W-1:0]        in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rfd_pkg::VALUE_W-1:0]     out_range_value,
  output logic [rfd_pkg::INDEX_W-1:0]     out_range_index,
  output logic                            out_last_word,
  input  logic                            cfg_wr_en,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                byte_accept;
  logic                q_push;
  logic                q_pop;
  rfd_pkg::word_t      q_in_item;
  rfd_pkg::word_t      q_head_item;
  rfd_pkg::q_status_t  q_status;

  // Hold bytes off only when no queue slot is free
  assign in_stall    = q_status.full;
  assign byte_accept = in_valid && !in_stall;

  // Front: hunt for the header, pair payload bytes into words
  rfd_front #(
    .MAX_HEADER (MAX_HEADER),
    .MAX_WORDS  (MAX_WORDS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_accept (byte_accept),
    .rx_byte     (in_rx_byte),
    .q_push      (q_push),
    .q_item      (q_in_item)
  );

  // Decouple front from a stalled output
  rfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .status    (q_status)
  );

  // Back: assemble range value and present it
  rfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (!q_status.empty),
    .q_item          (q_head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_range_value (out_range_value),
    .out_range_index (out_range_index),
    .out_last_word   (out_last_word)
  );

endmodule

// File: rtl/core/rfd_checker.sv
// Port-level checks of the range frame deframer and their bind.
module rfd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [rfd_pkg::VALUE_W-1:0]   out_range_value,
  input  logic [rfd_pkg::INDEX_W-1:0]   out_range_index,
  input  logic                          out_last_word
);

  logic                          out_take;
  logic [rfd_pkg::INDEX_W-1:0]   exp_idx_r;

  assign out_take = out_valid && !out_stall;

  // Track the index the next word must carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_take) begin
      exp_idx_r <= out_last_word ? '0 : out_range_index + rfd_pkg::INDEX_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range_value)
      && $stable(out_range_index) && $stable(out_last_word))
    else $error("stalled output word changed");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |-> out_range_index == exp_idx_r)
    else $error("range index out of sequence");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid))
    else $error("input stalled without a waiting output word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

endmodule

bind range_frame_deframer rfd_checker u_rfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_range_value (out_range_value),
  .out_range_index (out_range_index),
  .out_last_word   (out_last_word)
);

// File: tb/tb.sv
// Self-checking testbench for the range frame deframer: header hunt, word pairing, framing.
module tb;
  import rfd_pkg::*;

  // One expected range word, laid out as it leaves the block
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               last;
  } range_word_t;

  localparam int MAX_HDR_BYTES = 8;
  localparam int MAX_FRAME_WORDS = 512;
  // Cycles to let the block settle after the last word: queue plus output register
  localparam int SETTLE_CYCLES = 6;
  // Cycles with no transaction on either channel before the run is declared hung
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_BYTES = 60;
  localparam int LONG_FRAME_WORDS = 120;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [RX_W-1:0]       in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_W-1:0]    out_range_value;
  logic [INDEX_W-1:0]    out_range_index;
  logic                  out_last_word;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEADER_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Deframer shadow: registers as last written, plus hunt and pairing state
  logic [HDR_W-1:0]    hdr_pattern = HDR_RESET;
  logic [HLEN_W-1:0]   hdr_len_reg = HLEN_RESET;
  logic [PWORDS_W-1:0] words_reg   = PWORDS_RESET;
  logic [63:0]         hist        = '0;
  int unsigned         hist_fill   = 0;
  bit                  collecting  = 1'b0;
  int unsigned         word_idx    = 0;
  logic [7:0]          low_byte    = '0;
  bit                  have_low    = 1'b0;

  range_word_t pending_words[$];
  range_word_t next_word;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;

  int fail_count   = 0;
  int bytes_sent   = 0;
  int words_seen   = 0;
  int frames_seen  = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;

  range_frame_deframer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_range_value (out_range_value),
    .out_range_index (out_range_index),
    .out_last_word   (out_last_word),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clamp header length to 1..8; zero acts as one
  function automatic int unsigned eff_header_len();
    int unsigned k;
    k = hdr_len_reg;
    if (k < 1) k = 1;
    if (k > MAX_HDR_BYTES) k = MAX_HDR_BYTES;
    return k;
  endfunction

  // Clamp frame size to 1..512 words; zero acts as one
  function automatic int unsigned eff_payload_words();
    int unsigned w;
    w = words_reg;
    if (w < 1) w = 1;
    if (w > MAX_FRAME_WORDS) w = MAX_FRAME_WORDS;
    return w;
  endfunction

  // Bias toward the all-zero and all-one bytes now and then
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom());
  endfunction

  // Advance the shadow deframer by one accepted byte; queue the word it completes
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned k;
    int unsigned words;
    bit hit;
    range_word_t w;
    k = eff_header_len();
    words = eff_payload_words();
    if (!collecting) begin
      // Hunt: shift in, then compare the newest k bytes, oldest against header byte 0
      hist = {hist[55:0], b};
      if (hist_fill < MAX_HDR_BYTES) hist_fill++;
      hit = (hist_fill >= k);
      for (int j = 0; j < k; j++) begin
        if (hist[8*(k-1-j) +: 8] != hdr_pattern[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        collecting = 1'b1;
        hist = '0;
        hist_fill = 0;
        word_idx = 0;
        have_low = 1'b0;
        low_byte = '0;
      end
    end else if (!have_low) begin
      low_byte = b;
      have_low = 1'b1;
    end else begin
      // High byte completes the word; a shrunken frame size ends the frame at once
      w.value = {b, low_byte};
      w.index = word_idx[INDEX_W-1:0];
      w.last  = (word_idx + 1 >= words);
      pending_words.push_back(w);
      have_low = 1'b0;
      if (w.last) begin
        collecting = 1'b0;
        hist = '0;
        hist_fill = 0;
        word_idx = 0;
      end else begin
        word_idx++;
      end
    end
  endtask

  // Offer one byte, with an optional random gap first; hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    deframe_byte(b);
  endtask

  // Drop valid and wait until every expected word has come out, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; callers drain first so the block is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_HEADER_BYTES:  hdr_pattern = val[HDR_W-1:0];
      CFG_HEADER_LEN:    hdr_len_reg = val[HLEN_W-1:0];
      CFG_PAYLOAD_WORDS: words_reg   = val[PWORDS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Send the configured header, oldest byte first
  task automatic send_header();
    int unsigned k;
    k = eff_header_len();
    for (int j = 0; j < k; j++) send_byte(hdr_pattern[8*j +: 8]);
  endtask

  task automatic send_payload(input int unsigned n_words);
    for (int i = 0; i < 2 * n_words; i++) send_byte(rand_byte());
  endtask

  // Reset registers: all-zero header of 7 bytes. The zeroed history must not count
  // toward a match, so only the seventh zero starts the frame. Then shrink the frame
  // below the current index mid-frame: the next word must end it.
  task automatic test_reset_defaults_and_resize();
    repeat (7) send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h34);
    drain_results();
    write_reg(CFG_PAYLOAD_WORDS, '0);
    send_byte(8'h12);
  endtask

  // Header length zero acts as one, fifteen as eight; payload bytes equal to the
  // header must not restart the hunt.
  task automatic test_header_len_limits();
    drain_results();
    write_reg(CFG_HEADER_BYTES, '1);
    write_reg(CFG_HEADER_LEN, '0);
    repeat (3) send_byte(8'hFF);
    drain_results();
    write_reg(CFG_HEADER_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(CFG_HEADER_LEN, 64'd15);
    send_header();
    send_byte(8'hCD);
    send_byte(8'hAB);
  endtask

  // A payload ending in the last header byte must not combine with bytes after the
  // frame: the history starts empty again.
  task automatic test_history_cleared_after_frame();
    drain_results();
    write_reg(CFG_HEADER_BYTES, 64'hFFFF_FFFF_FFFF_3CA5);
    write_reg(CFG_HEADER_LEN, 64'd2);
    send_header();
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_header();
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // Frame size above the ceiling acts as 512 words: a long frame runs with no last
  // mark, then shrinking the size ends it on the next word
  task automatic test_long_frame_resize();
    drain_results();
    write_reg(CFG_HEADER_BYTES, {$urandom(), $urandom()});
    write_reg(CFG_HEADER_LEN, 64'd3);
    write_reg(CFG_PAYLOAD_WORDS, 64'd1023);
    send_header();
    send_payload(LONG_FRAME_WORDS);
    drain_results();
    write_reg(CFG_PAYLOAD_WORDS, 64'd2);
    send_payload(1);
  endtask

  // Random phases: mostly complete frames with random content, mixed with noise,
  // cut-off headers and pauses for the output to drain. Fresh settings per phase.
  task automatic test_random_traffic(input int n_phases);
    int unsigned frame_bytes;
    int unsigned k;
    int unsigned n_pre;
    logic [7:0] fill;
    for (int p = 0; p < n_phases; p++) begin
      if (p == n_phases - 1) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      drain_results();
      if (p % 3 == 0) begin
        fill = rand_byte();
        write_reg(CFG_HEADER_BYTES, {8{fill}});
      end else begin
        write_reg(CFG_HEADER_BYTES, {$urandom(), $urandom()});
      end
      write_reg(CFG_HEADER_LEN, 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                  : $urandom_range(1, 8)));
      write_reg(CFG_PAYLOAD_WORDS, 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24)
                                                                     : $urandom_range(1, 6)));
      frame_bytes = 0;
      while (frame_bytes < PHASE_BYTES) begin
        k = eff_header_len();
        case ($urandom_range(0, 9))
          0: begin
            // Line noise, sometimes sprinkled with header bytes
            repeat ($urandom_range(1, 6)) begin
              if ($urandom_range(0, 3) == 0)
                send_byte(hdr_pattern[8*$urandom_range(0, k-1) +: 8]);
              else
                send_byte(rand_byte());
            end
          end
          1: begin
            // Broken header: a prefix, then a random byte
            n_pre = $urandom_range(0, k-1);
            for (int j = 0; j < n_pre; j++) send_byte(hdr_pattern[8*j +: 8]);
            send_byte(rand_byte());
          end
          2: drain_results();
          default: begin
            send_header();
            send_payload(eff_payload_words());
            frame_bytes += k + 2 * eff_payload_words();
          end
        endcase
      end
    end
  endtask

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected range word: value %h index %0d last %0b",
               out_range_value, out_range_index, out_last_word);
        fail_count++;
      end else begin
        next_word = pending_words.pop_front();
        if (out_range_value !== next_word.value) begin
          $error("range_value: expected %h, got %h", next_word.value, out_range_value);
          fail_count++;
        end
        if (out_range_index !== next_word.index) begin
          $error("range_index: expected %0d, got %0d", next_word.index, out_range_index);
          fail_count++;
        end
        if (out_last_word !== next_word.last) begin
          $error("last_word: expected %0b, got %0b", next_word.last, out_last_word);
          fail_count++;
        end
        words_seen++;
        if (out_last_word === 1'b1) frames_seen++;
      end
    end
  end

  // Output side: stall in random bursts
  always begin
    @(negedge clk);
    if (stall_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Hang detector: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults_and_resize();
    test_header_len_limits();
    test_history_cleared_after_frame();
    test_long_frame_resize();
    test_random_traffic(3);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d bytes in, %0d range words over %0d frames, %0d register writes",
             bytes_sent, words_seen, frames_seen, reg_writes);
    $display("summary: clamped header lengths and sizes, short frames, one long frame cut short");
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rfd_pkg.sv
rtl/core/rfd_front.sv
rtl/core/rfd_queue.sv
rtl/core/rfd_back.sv
rtl/core/range_frame_deframer.sv
rtl/core/rfd_checker.sv
tb/tb.sv
